// ----- rtl/core/framebuffer_pixel_writer_macros.svh -----
// assertion macros used by the framebuffer pixel writer checker
`ifndef FRAMEBUFFER_PIXEL_WRITER_MACROS_SVH
`define FRAMEBUFFER_PIXEL_WRITER_MACROS_SVH

// expression must hold at every clock edge out of reset
`define FBPW_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequent must hold whenever the antecedent holds
`define FBPW_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/fbpw_pkg.sv -----
// types, register codes and constants of the framebuffer pixel writer
package fbpw_pkg;

  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_FRAME_BASE    = 3'd0,
    REG_SCREEN_WIDTH  = 3'd1,
    REG_SCREEN_HEIGHT = 3'd2,
    REG_ROW_PITCH     = 3'd3,
    REG_BYTES_PER_PIX = 3'd4,
    REG_CHAN_SIZES    = 3'd5,
    REG_CHAN_POS      = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    PIX_2B,
    PIX_3B,
    PIX_4B
  } pix_size_e;

  localparam logic [2:0] BPP_THREE = 3'd3;
  localparam logic [2:0] BPP_FOUR  = 3'd4;

  localparam logic [3:0]  BE_2B   = 4'h3;
  localparam logic [3:0]  BE_3B   = 4'h7;
  localparam logic [3:0]  BE_4B   = 4'hF;
  localparam logic [31:0] MASK_2B = 32'h0000_FFFF;
  localparam logic [31:0] MASK_3B = 32'h00FF_FFFF;
  localparam logic [31:0] MASK_4B = 32'hFFFF_FFFF;

  localparam logic [31:0] RST_FRAME_BASE    = 32'd0;
  localparam logic [14:0] RST_SCREEN_WIDTH  = 15'd640;
  localparam logic [14:0] RST_SCREEN_HEIGHT = 15'd480;
  localparam logic [15:0] RST_ROW_PITCH     = 16'd2560;
  localparam logic [2:0]  RST_BYTES_PER_PIX = 3'd4;
  localparam logic [11:0] RST_CHAN_SIZES    = 12'd2184;
  localparam logic [14:0] RST_CHAN_POS      = 15'd16640;

  typedef struct packed {
    logic [31:0] frame_base;
    logic [14:0] screen_width;
    logic [14:0] screen_height;
    logic [15:0] row_pitch;
    logic [2:0]  bytes_per_pixel;
    logic [11:0] channel_sizes;
    logic [14:0] channel_positions;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic [23:0]        color_rgb;
  } pixel_t;

  typedef struct packed {
    logic [31:0] write_address;
    logic [31:0] write_data;
    logic [3:0]  byte_enables;
  } result_t;

  function automatic pix_size_e pix_size(input logic [2:0] bpp);
    pix_size_e s;
    if (bpp == BPP_FOUR) begin
      s = PIX_4B;
    end else if (bpp == BPP_THREE) begin
      s = PIX_3B;
    end else begin
      s = PIX_2B;
    end
    return s;
  endfunction

endpackage

// ----- rtl/core/fbpw_cfg.sv -----
// apb configuration register file
module fbpw_cfg
  import fbpw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = paddr[APB_ADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_FRAME_BASE:    cfg_d.frame_base        = pwdata[31:0];
        REG_SCREEN_WIDTH:  cfg_d.screen_width      = pwdata[14:0];
        REG_SCREEN_HEIGHT: cfg_d.screen_height     = pwdata[14:0];
        REG_ROW_PITCH:     cfg_d.row_pitch         = pwdata[15:0];
        REG_BYTES_PER_PIX: cfg_d.bytes_per_pixel   = pwdata[2:0];
        REG_CHAN_SIZES:    cfg_d.channel_sizes     = pwdata[11:0];
        REG_CHAN_POS:      cfg_d.channel_positions = pwdata[14:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_base        <= RST_FRAME_BASE;
      cfg_q.screen_width      <= RST_SCREEN_WIDTH;
      cfg_q.screen_height     <= RST_SCREEN_HEIGHT;
      cfg_q.row_pitch         <= RST_ROW_PITCH;
      cfg_q.bytes_per_pixel   <= RST_BYTES_PER_PIX;
      cfg_q.channel_sizes     <= RST_CHAN_SIZES;
      cfg_q.channel_positions <= RST_CHAN_POS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    unique case (idx)
      REG_FRAME_BASE:    prdata = cfg_q.frame_base;
      REG_SCREEN_WIDTH:  prdata = {17'd0, cfg_q.screen_width};
      REG_SCREEN_HEIGHT: prdata = {17'd0, cfg_q.screen_height};
      REG_ROW_PITCH:     prdata = {16'd0, cfg_q.row_pitch};
      REG_BYTES_PER_PIX: prdata = {29'd0, cfg_q.bytes_per_pixel};
      REG_CHAN_SIZES:    prdata = {20'd0, cfg_q.channel_sizes};
      REG_CHAN_POS:      prdata = {17'd0, cfg_q.channel_positions};
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/fbpw_chan.sv -----
// one color channel: rescale 8 bits to n bits with rounding, then shift into place
module fbpw_chan (
  input  logic [7:0]  color_i,
  input  logic [3:0]  size_i,
  input  logic [4:0]  pos_i,
  output logic [31:0] field_o
);

  logic [22:0] scaled;
  logic [22:0] num;
  logic [23:0] approx;
  logic [15:0] quot;
  logic [23:0] rem;
  logic [14:0] level;

  // num = c * (2^n - 1) + 127
  assign scaled = (23'(color_i) << size_i) - 23'(color_i);
  assign num    = scaled + 23'd127;

  // num / 255 from num/256 * (1 + 1/256 + 1/65536), low by at most one
  assign approx = 24'(num) + 24'(num >> 8) + 24'(num >> 16);
  assign quot   = approx[23:8];
  assign rem    = 24'(num) - (({8'd0, quot} << 8) - 24'(quot));
  assign level  = (rem >= 24'd255) ? 15'(quot + 16'd1) : quot[14:0];

  assign field_o = {17'd0, level} << pos_i;

endmodule

// ----- rtl/core/fbpw_addr.sv -----
// screen bounds check and byte address of a pixel
module fbpw_addr
  import fbpw_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic [15:0] pixel_x_i,
  input  logic [15:0] pixel_y_i,
  input  cfg_t        cfg_i,
  output logic        hit_o,
  output logic [31:0] addr_o
);

  localparam int unsigned CW  = COORD_BITS - 1;
  localparam int unsigned AXW = (ADDR_BITS > 32) ? ADDR_BITS : 32;

  logic [CW-1:0]        xv;
  logic [CW-1:0]        yv;
  logic                 x_neg;
  logic                 y_neg;
  logic [CW+15:0]       row_off;
  logic [CW+1:0]        col_off;
  logic [ADDR_BITS-1:0] addr;
  logic [AXW-1:0]       addr_ext;

  assign x_neg = pixel_x_i[COORD_BITS-1];
  assign y_neg = pixel_y_i[COORD_BITS-1];
  assign xv    = pixel_x_i[CW-1:0];
  assign yv    = pixel_y_i[CW-1:0];

  assign hit_o = !x_neg && !y_neg
              && (15'(xv) < cfg_i.screen_width)
              && (15'(yv) < cfg_i.screen_height);

  assign row_off = (CW+16)'(yv) * (CW+16)'(cfg_i.row_pitch);

  always_comb begin
    unique case (pix_size(cfg_i.bytes_per_pixel))
      PIX_4B:  col_off = (CW+2)'(xv) << 2;
      PIX_3B:  col_off = ((CW+2)'(xv) << 1) + (CW+2)'(xv);
      default: col_off = (CW+2)'(xv) << 1;
    endcase
  end

  assign addr     = ADDR_BITS'(cfg_i.frame_base) + ADDR_BITS'(row_off)
                  + ADDR_BITS'(col_off);
  assign addr_ext = AXW'(addr);
  assign addr_o   = addr_ext[31:0];

endmodule

// ----- rtl/core/framebuffer_pixel_writer.sv -----
// framebuffer pixel writer top level
//
// Turns pixel write requests (signed x, y, 24-bit RGB) into byte-addressed,
// byte-enabled framebuffer writes in the configured pixel format.
// Input: a word is taken at each rising edge with start high and busy low;
// busy is held low, so one pixel is taken every cycle.
// Output: result_valid_o marks result_o for exactly one cycle; the receiver
// takes it at the edge that ends that cycle and cannot hold it off.
// Pipeline: a taken word goes into the input register and its result into
// the result register, which drives the ports; one pixel per cycle.
// A pixel outside the screen, or with a negative coordinate, gives no result.
// Configuration: APB-style registers at byte addresses 4*i; pready is always
// high. The user writes them only while no pixel is in flight; not enforced.
// Reset: rst_ni clears the pipeline valid bits and loads register defaults
// (640x480, pitch 2560, 4 bytes per pixel, 8:8:8 at 16/8/0).
module framebuffer_pixel_writer
  import fbpw_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned ADDR_BITS  = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  start,
  output logic                  busy,
  input  pixel_t                pixel_i,
  output logic                  result_valid_o,
  output result_t               result_o
);

  cfg_t        cfg;
  logic        in_valid_q;
  pixel_t      pixel_q;
  logic        hit;
  logic [31:0] addr;
  logic [31:0] red_f;
  logic [31:0] green_f;
  logic [31:0] blue_f;
  logic [31:0] packed_word;
  result_t     result_d, result_q;
  logic        result_valid_d, result_valid_q;

  assign busy = 1'b0;

  fbpw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      pixel_q <= pixel_i;
    end
  end

  fbpw_addr #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_addr (
    .pixel_x_i (pixel_q.pixel_x),
    .pixel_y_i (pixel_q.pixel_y),
    .cfg_i     (cfg),
    .hit_o     (hit),
    .addr_o    (addr)
  );

  fbpw_chan u_red (
    .color_i (pixel_q.color_rgb[23:16]),
    .size_i  (cfg.channel_sizes[11:8]),
    .pos_i   (cfg.channel_positions[14:10]),
    .field_o (red_f)
  );

  fbpw_chan u_green (
    .color_i (pixel_q.color_rgb[15:8]),
    .size_i  (cfg.channel_sizes[7:4]),
    .pos_i   (cfg.channel_positions[9:5]),
    .field_o (green_f)
  );

  fbpw_chan u_blue (
    .color_i (pixel_q.color_rgb[7:0]),
    .size_i  (cfg.channel_sizes[3:0]),
    .pos_i   (cfg.channel_positions[4:0]),
    .field_o (blue_f)
  );

  assign packed_word = red_f | green_f | blue_f;

  always_comb begin
    result_d.write_address = addr;
    unique case (pix_size(cfg.bytes_per_pixel))
      PIX_4B: begin
        result_d.write_data   = packed_word & MASK_4B;
        result_d.byte_enables = BE_4B;
      end
      PIX_3B: begin
        result_d.write_data   = packed_word & MASK_3B;
        result_d.byte_enables = BE_3B;
      end
      default: begin
        result_d.write_data   = packed_word & MASK_2B;
        result_d.byte_enables = BE_2B;
      end
    endcase
  end

  assign result_valid_d = in_valid_q && hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= result_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (result_valid_d) begin
      result_q <= result_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

endmodule

// ----- rtl/core/fbpw_checker.sv -----
// port-level checks of the framebuffer pixel writer and their bind
`include "framebuffer_pixel_writer_macros.svh"

module fbpw_checker
  import fbpw_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start,
  input logic    busy,
  input logic    pready,
  input logic    result_valid_o,
  input result_t result_o
);

  `FBPW_ASSERT_IMPLIES(a_result_follows_word, clk_i, rst_ni, result_valid_o, $past(start && !busy, 2), "result without a word taken two cycles before")
  `FBPW_ASSERT_IMPLIES(a_enables_legal, clk_i, rst_ni, result_valid_o, result_o.byte_enables == BE_4B || result_o.byte_enables == BE_3B || result_o.byte_enables == BE_2B, "illegal byte enable pattern")
  `FBPW_ASSERT_IMPLIES(a_two_byte_data, clk_i, rst_ni, result_valid_o && result_o.byte_enables == BE_2B, result_o.write_data[31:16] == 16'd0, "disabled bytes carry data")
  `FBPW_ASSERT_IMPLIES(a_three_byte_data, clk_i, rst_ni, result_valid_o && result_o.byte_enables == BE_3B, result_o.write_data[31:24] == 8'd0, "disabled byte carries data")
  `FBPW_ASSERT_ALWAYS(a_never_stalls, clk_i, rst_ni, !busy && pready, "block stalled a channel")

endmodule

bind framebuffer_pixel_writer fbpw_checker u_fbpw_checker (.*);

// ----- verif/testbench.sv -----
// self-checking testbench for the framebuffer pixel writer: pixel words in, framebuffer writes out
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpw_pkg::*;

  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned ADDR_BITS   = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned RAND_PHASES = 10;
  localparam int unsigned PHASE_WORDS = 85;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  start   = 1'b0;
  logic                  busy;
  pixel_t                pixel_i = '0;
  logic                  result_valid_o;
  result_t               result_o;

  framebuffer_pixel_writer #(
    .COORD_BITS(COORD_BITS),
    .ADDR_BITS (ADDR_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .start         (start),
    .busy          (busy),
    .pixel_i       (pixel_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  cfg_t        fb_cfg;
  pixel_t      pixel_queue[$];
  result_t     pending_writes[$];
  int unsigned fail_count    = 0;
  int unsigned words_taken   = 0;
  int unsigned words_dropped = 0;
  int unsigned writes_seen   = 0;
  int unsigned settings_used = 1;
  int unsigned cycles        = 0;
  int          gap_style     = 0;
  int          gap_left      = 0;
  bit          took          = 1'b0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic logic [31:0] scale_channel(logic [7:0] c, logic [3:0] n, logic [4:0] sh);
    logic [31:0] top;
    logic [31:0] v;
    if (n == 4'd0) begin
      return 32'd0;
    end
    top = (32'd1 << n) - 32'd1;
    v = ({24'd0, c} * top + 32'd127) / 32'd255;
    return v << sh;
  endfunction

  function automatic bit predict_fb_write(pixel_t p, output result_t w);
    logic [15:0] xr;
    logic [15:0] yr;
    logic [31:0] xv;
    logic [31:0] yv;
    logic [31:0] nb;
    logic [31:0] dmask;
    logic [31:0] pix;
    logic [3:0]  be;
    w  = '0;
    xr = p.pixel_x;
    yr = p.pixel_y;
    if (xr[15] || yr[15]) begin
      return 1'b0;
    end
    if (xr[14:0] >= fb_cfg.screen_width || yr[14:0] >= fb_cfg.screen_height) begin
      return 1'b0;
    end
    xv = {17'd0, xr[14:0]};
    yv = {17'd0, yr[14:0]};
    pix = scale_channel(p.color_rgb[23:16], fb_cfg.channel_sizes[11:8],
                        fb_cfg.channel_positions[14:10])
        | scale_channel(p.color_rgb[15:8], fb_cfg.channel_sizes[7:4],
                        fb_cfg.channel_positions[9:5])
        | scale_channel(p.color_rgb[7:0], fb_cfg.channel_sizes[3:0],
                        fb_cfg.channel_positions[4:0]);
    if (fb_cfg.bytes_per_pixel == BPP_FOUR) begin
      nb = 32'd4; be = BE_4B; dmask = MASK_4B;
    end else if (fb_cfg.bytes_per_pixel == BPP_THREE) begin
      nb = 32'd3; be = BE_3B; dmask = MASK_3B;
    end else begin
      nb = 32'd2; be = BE_2B; dmask = MASK_2B;
    end
    w.write_address = fb_cfg.frame_base + yv * {16'd0, fb_cfg.row_pitch} + xv * nb;
    w.write_data    = pix & dmask;
    w.byte_enables  = be;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_style == 0 || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  // driver: words change on the falling edge, a refused word is held
  always @(negedge clk_i) begin
    if (start && !took) begin
    end else if (gap_left != 0) begin
      start    <= 1'b0;
      gap_left = gap_left - 1;
    end else if (rst_ni && pixel_queue.size() != 0) begin
      start    <= 1'b1;
      pixel_i  <= pixel_queue[0];
      gap_left = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: predicts on every taken word, checks every write strobe
  always @(posedge clk_i) begin : monitor
    result_t predicted;
    result_t want;
    took = 1'b0;
    if (rst_ni) begin
      if (start && !busy) begin
        took = 1'b1;
        words_taken++;
        if (predict_fb_write(pixel_i, predicted)) begin
          pending_writes.push_back(predicted);
        end else begin
          words_dropped++;
        end
        void'(pixel_queue.pop_front());
      end
      if (result_valid_o) begin
        if (pending_writes.size() == 0) begin
          note_fail($sformatf("unexpected write addr %h data %h be %h",
                              result_o.write_address, result_o.write_data,
                              result_o.byte_enables));
        end else begin
          want = pending_writes.pop_front();
          writes_seen++;
          if (result_o.write_address !== want.write_address ||
              result_o.write_data !== want.write_data ||
              result_o.byte_enables !== want.byte_enables) begin
            note_fail($sformatf("addr %h/%h data %h/%h be %h/%h (expected/actual)",
                                want.write_address, result_o.write_address,
                                want.write_data, result_o.write_data,
                                want.byte_enables, result_o.byte_enables));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_settings(cfg_t c);
    apb_write(REG_FRAME_BASE,    c.frame_base);
    apb_write(REG_SCREEN_WIDTH,  {17'd0, c.screen_width});
    apb_write(REG_SCREEN_HEIGHT, {17'd0, c.screen_height});
    apb_write(REG_ROW_PITCH,     {16'd0, c.row_pitch});
    apb_write(REG_BYTES_PER_PIX, {29'd0, c.bytes_per_pixel});
    apb_write(REG_CHAN_SIZES,    {20'd0, c.channel_sizes});
    apb_write(REG_CHAN_POS,      {17'd0, c.channel_positions});
    fb_cfg = c;
    settings_used++;
  endtask

  // wait for the pipeline to drain, including words that give no write
  task automatic settle();
    while (pixel_queue.size() != 0 || pending_writes.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_px(int x, int y, logic [23:0] rgb);
    pixel_t p;
    p.pixel_x   = x[15:0];
    p.pixel_y   = y[15:0];
    p.color_rgb = rgb;
    pixel_queue.push_back(p);
  endtask

  function automatic logic [14:0] random_extent();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      return 15'($urandom_range(1, 8));
    end else if (r < 6) begin
      return 15'($urandom_range(1, 1024));
    end else if (r < 8) begin
      return 15'($urandom_range(1, 32767));
    end else if (r == 8) begin
      return 15'd32767;
    end
    return 15'd640;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t c;
    c.frame_base      = $urandom;
    c.screen_width    = random_extent();
    c.screen_height   = random_extent();
    c.bytes_per_pixel = 3'($urandom_range(0, 7));
    if ($urandom_range(0, 1)) begin
      c.row_pitch = 16'($urandom_range(0, 65535));
    end else begin
      c.row_pitch = c.screen_width * 16'd4;
    end
    if ($urandom_range(0, 1)) begin
      c.channel_sizes = {4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)),
                         4'($urandom_range(0, 8))};
    end else begin
      c.channel_sizes = 12'($urandom_range(0, 4095));
    end
    c.channel_positions = 15'($urandom_range(0, 32767));
    return c;
  endfunction

  function automatic pixel_t random_pixel(cfg_t c);
    pixel_t      p;
    int          kind;
    logic [15:0] x;
    logic [15:0] y;
    kind = $urandom_range(0, 9);
    x = 16'($urandom);
    y = 16'($urandom);
    if (kind < 7 && c.screen_width != 0 && c.screen_height != 0) begin
      x = 16'($urandom_range(0, c.screen_width - 1));
      y = 16'($urandom_range(0, c.screen_height - 1));
      if (kind == 0) x = 16'(c.screen_width - 1);
      if (kind == 1) y = 16'(c.screen_height - 1);
    end else if (kind == 7) begin
      x[15] = 1'b0;
      y[15] = 1'b0;
      if ($urandom_range(0, 1)) begin
        x = 16'($urandom_range(c.screen_width, 32767));
      end else begin
        y = 16'($urandom_range(c.screen_height, 32767));
      end
    end else if (kind == 8) begin
      if ($urandom_range(0, 1)) x[15] = 1'b1;
      else y[15] = 1'b1;
    end
    p.pixel_x = x;
    p.pixel_y = y;
    if ($urandom_range(0, 7) == 0) begin
      p.color_rgb = {($urandom_range(0, 1) ? 8'hFF : 8'h00),
                     ($urandom_range(0, 1) ? 8'hFF : 8'h00),
                     ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
    end else begin
      p.color_rgb = 24'($urandom);
    end
    return p;
  endfunction

  initial begin
    cfg_t c;
    int   ph;
    int   k;
    fb_cfg = '{frame_base: RST_FRAME_BASE, screen_width: RST_SCREEN_WIDTH,
               screen_height: RST_SCREEN_HEIGHT, row_pitch: RST_ROW_PITCH,
               bytes_per_pixel: RST_BYTES_PER_PIX, channel_sizes: RST_CHAN_SIZES,
               channel_positions: RST_CHAN_POS};
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset defaults: corners, edges, negative and far-out coordinates
    gap_style = 1;
    push_px(0, 0, 24'h000000);
    push_px(639, 479, 24'hFFFFFF);
    push_px(640, 0, 24'h123456);
    push_px(0, 480, 24'h654321);
    push_px(-1, 5, 24'hABCDEF);
    push_px(5, -1, 24'hFEDCBA);
    push_px(-32768, -32768, 24'hFFFFFF);
    push_px(32767, 32767, 24'hFFFFFF);
    push_px(1, 1, 24'hFF0000);
    push_px(2, 3, 24'h00FF00);
    push_px(3, 2, 24'h0000FF);
    push_px(100, 200, 24'h808080);
    settle();

    // widest registers: address wrap, 15-bit channels shifted past bit 31
    load_settings('{frame_base: 32'hFFFF_FFFF, screen_width: 15'h7FFF,
                    screen_height: 15'h7FFF, row_pitch: 16'hFFFF,
                    bytes_per_pixel: BPP_THREE, channel_sizes: 12'hFFF,
                    channel_positions: 15'h7FFF});
    push_px(32766, 32766, 24'hFFFFFF);
    push_px(0, 0, 24'hFFFFFF);
    push_px(32767, 0, 24'hFFFFFF);
    push_px(1, 0, 24'h010101);
    settle();

    // one-pixel screen, zero pitch, zero-width channels, odd pixel size
    load_settings('{frame_base: 32'd0, screen_width: 15'd1, screen_height: 15'd1,
                    row_pitch: 16'd0, bytes_per_pixel: 3'd0, channel_sizes: 12'd0,
                    channel_positions: 15'd0});
    push_px(0, 0, 24'hFFFFFF);
    push_px(1, 0, 24'hFFFFFF);
    push_px(0, 1, 24'hFFFFFF);
    settle();

    // 5:6:5 in two bytes
    load_settings('{frame_base: 32'h1000_0000, screen_width: 15'd320,
                    screen_height: 15'd240, row_pitch: 16'd640, bytes_per_pixel: 3'd2,
                    channel_sizes: 12'h565, channel_positions: {5'd11, 5'd5, 5'd0}});
    push_px(319, 239, 24'hFFFFFF);
    push_px(0, 0, 24'h7F7F7F);
    settle();

    // zero-size screen rejects everything
    load_settings('{frame_base: 32'h0000_0100, screen_width: 15'd0,
                    screen_height: 15'd0, row_pitch: 16'd8, bytes_per_pixel: 3'd7,
                    channel_sizes: 12'h888, channel_positions: 15'd0});
    push_px(0, 0, 24'h55AA55);
    settle();

    for (ph = 0; ph < RAND_PHASES; ph++) begin
      c = random_settings();
      load_settings(c);
      gap_style = ph % 2;
      for (k = 0; k < PHASE_WORDS; k++) begin
        pixel_queue.push_back(random_pixel(c));
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (pending_writes.size() != 0) begin
      note_fail($sformatf("%0d writes never arrived", pending_writes.size()));
    end
    $display("%0d pixel words under %0d register settings: %0d writes checked, %0d off-screen",
             words_taken, settings_used, writes_seen, words_dropped);
    $display("%0d mismatches", fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
